// ===== rtl/mast_pkg.sv =====
// Package with payload types and fixed constants of the step tuner.
`default_nettype none
package mast_pkg;

	// Request codes.
	localparam logic [2:0] REQ_ACCEPT = 3'd0;
	localparam logic [2:0] REQ_REJECT = 3'd1;
	localparam logic [2:0] REQ_TUNE   = 3'd2;
	localparam logic [2:0] REQ_CLEAR  = 3'd3;
	localparam logic [2:0] REQ_WRITE  = 3'd4;

	// Register indexes on the configuration port.
	localparam logic REG_SKIP = 1'b0;
	localparam logic REG_CONC = 1'b1;

	// Mask width and reset values.
	localparam int MASK_BITS = 9;
	localparam logic [MASK_BITS-1:0] SKIP_RESET = 9'd96;
	localparam logic [MASK_BITS-1:0] CONC_RESET = 9'd254;

	// Target acceptance rate 0.33 and its complement 0.67 in Q0.16.
	localparam logic [15:0] RATE_TARGET = 16'd21627;
	localparam logic [15:0] RATE_REST   = 16'd43909;

	// Reciprocals of the two rate divisors, scaled by 2^48 and rounded up. For a 16-bit
	// operand x, (x * RECIP) >> 32 equals floor(x * 65536 / divisor) exactly.
	localparam logic [63:0] TWO_POW_48   = 64'd1 << 48;
	localparam logic [33:0] RECIP_TARGET =
		34'((TWO_POW_48 + 64'(RATE_TARGET) - 64'd1) / 64'(RATE_TARGET));
	localparam logic [33:0] RECIP_REST   =
		34'((TWO_POW_48 + 64'(RATE_REST) - 64'd1) / 64'(RATE_REST));

	// Width of the scale factor in Q2.16.
	localparam int FBITS = 18;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [3:0]  move_index;
		logic [31:0] step_value;
	} req_t;

	typedef struct packed {
		logic        status;
		logic [3:0]  out_index;
		logic [31:0] out_value;
		logic        last;
	} rsp_t;

endpackage
`default_nettype wire

// ===== rtl/mcmc_acceptance_step_tuner_core.sv =====
// Top level of the step tuner: counter and step memories, request sequencer and tune datapath.
`default_nettype none
// Accept, reject, write and clear requests read the entry from memory in the cycle the word
// is accepted and write it back from the S_EX state once the output register is free. A tune
// request walks the move kinds one at a time. A move without tries only advances the scan; a
// skipped move passes through scan, load and write-back. A retuned move passes through a scan
// and a load state, one pass of the bit-serial rate divider, the scale factor state, which
// comes from a reciprocal multiplication, then a second divider pass when the step shrinks
// by division or a shift-add multiply when it grows, and a write-back state.
// Each write-back waits for the output register to be free. Results leave through one output
// register; a new request is taken while a finished result still waits there. No clearing
// pass is needed after reset.
module mcmc_acceptance_step_tuner_core
	import mast_pkg::*;
#(
	parameter int NUM_MOVES  = 9,
	parameter int COUNT_BITS = 32,
	parameter int STEP_BITS  = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire req_t        req,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output rsp_t             rsp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int IW   = (NUM_MOVES > 1) ? $clog2(NUM_MOVES) : 1;
	localparam int SCW  = $clog2(NUM_MOVES + 1);
	localparam int CW   = COUNT_BITS;
	localparam int SW   = STEP_BITS;
	localparam int XW   = (SW > 32) ? SW : 32;
	localparam int DVW  = ((CW > SW) ? CW : SW) + 16;
	localparam int DSW  = (CW > FBITS) ? CW : FBITS;
	localparam int DCW  = $clog2(DVW + 1);
	localparam int PW   = SW + FBITS;
	localparam logic [CW-1:0] CNT_MAX = '1;
	localparam logic [SW-1:0] STEP_MAX = '1;
	localparam logic [SW-1:0] STEP_INIT = (SW > 16) ? SW'(65536) : '1;

	// Sequencer states.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EX   = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_LOAD = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_MUL  = 3'd5;
	localparam logic [2:0] S_WB   = 3'd6;
	localparam logic [2:0] S_FAC  = 3'd7;

	// Divider passes.
	localparam logic [1:0] PH_RATE = 2'd0;
	localparam logic [1:0] PH_STEP = 2'd1;

	logic [2:0]            state_q;
	req_t                  req_q;
	logic [MASK_BITS-1:0]  skip_q, conc_q;
	logic [NUM_MOVES-1:0]  cvalid_q, svalid_q, act_q;
	logic [SCW-1:0]        scan_q;
	logic [IW-1:0]         rd_addr_q;
	logic [2*CW-1:0]       cnt_mem [NUM_MOVES];
	logic [SW-1:0]         step_mem [NUM_MOVES];
	logic [2*CW-1:0]       cnt_rd_q;
	logic [SW-1:0]         step_rd_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	// Tune datapath registers.
	logic [SW-1:0]         tn_step_q;
	logic                  gt_q, up_q;
	logic [15:0]           fx_q;
	logic [1:0]            dv_phase_q;
	logic [DVW-1:0]        dv_num_q;
	logic [DSW-1:0]        dv_den_q;
	logic [DSW:0]          dv_rem_q;
	logic [DCW-1:0]        dv_cnt_q;
	logic [FBITS-1:0]      mp_q;
	logic [PW-1:0]         mc_q, prod_q;

	logic                  accept, out_free, ex_ok, rd_en, rsp_set;
	logic [IW-1:0]         ex_addr, scan_idx, rd_addr;
	logic [CW-1:0]         cur_tr, cur_ac, ac_clamp;
	logic [SW-1:0]         cur_step, wr_step;
	logic [31:0]           mask_skip_x, mask_conc_x;
	logic                  tune_last;
	logic [DSW:0]          rem_sh;
	logic                  qbit;
	logic [15:0]           rate;
	logic [33:0]           recip;
	logic [49:0]           fq_prod;
	logic [16:0]           fq;
	logic [SW+1:0]         mul_res;
	logic [SW-1:0]         mul_step, div_step;
	logic [FBITS-1:0]      fac;
	logic [XW-1:0]         sv_x;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign pready    = 1'b1;

	// Register reads.
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_SKIP: prdata = 32'(skip_q);
			REG_CONC: prdata = 32'(conc_q);
			default:  prdata = '0;
		endcase
	end

	// Index decode, read port selection and current entry values.
	always_comb begin
		ex_addr     = IW'(6'({2'b00, req_q.move_index}));
		ex_ok       = (6'({2'b00, req_q.move_index}) < 6'(NUM_MOVES));
		scan_idx    = scan_q[IW-1:0];
		rd_en       = accept || (state_q == S_SCAN && scan_q != SCW'(NUM_MOVES)
			&& act_q[scan_idx]);
		rd_addr     = accept ? IW'(6'({2'b00, req.move_index})) : scan_idx;
		cur_tr      = cvalid_q[rd_addr_q] ? cnt_rd_q[CW-1:0] : '0;
		cur_ac      = cvalid_q[rd_addr_q] ? cnt_rd_q[2*CW-1:CW] : '0;
		ac_clamp    = (cur_ac > cur_tr) ? cur_tr : cur_ac;
		cur_step    = svalid_q[rd_addr_q] ? step_rd_q : STEP_INIT;
		mask_skip_x = 32'(skip_q);
		mask_conc_x = 32'(conc_q);
		sv_x        = XW'(req_q.step_value);
		wr_step     = (sv_x > XW'(STEP_MAX)) ? STEP_MAX : SW'(sv_x);
		// A result is loaded when an accept, reject, clear or write request finishes or a tuned move is written back.
		rsp_set     = out_free && ((state_q == S_WB) || (state_q == S_EX
			&& (req_q.req_type inside {REQ_ACCEPT, REQ_REJECT, REQ_CLEAR, REQ_WRITE})));
		// The final tune result is the one with no active move above it.
		tune_last   = 1'b1;
		for (int j = 0; j < NUM_MOVES; j++) begin
			if (j > int'(scan_q) && act_q[j])
				tune_last = 1'b0;
		end
	end

	// One restoring divider step, the scale factor and the results of each pass.
	always_comb begin
		rem_sh   = {dv_rem_q[DSW-1:0], dv_num_q[DVW-1]};
		qbit     = (rem_sh >= {1'b0, dv_den_q});
		rate     = (|dv_num_q[DVW-1:16]) ? 16'hFFFF : dv_num_q[15:0];
		recip    = gt_q ? RECIP_REST : RECIP_TARGET;
		fq_prod  = 50'(fx_q) * 50'(recip);
		fq       = fq_prod[48:32];
		fac      = gt_q ? (FBITS'(65536) + FBITS'(fq))
			: (FBITS'(131072) - FBITS'(fq));
		mul_res  = prod_q[PW-1:16];
		mul_step = (|mul_res[SW+1:SW]) ? STEP_MAX : mul_res[SW-1:0];
		if (mul_step == '0)
			mul_step = SW'(1);
		div_step = dv_num_q[SW-1:0];
		if (div_step == '0)
			div_step = SW'(1);
	end

	// Memories: counters as {accepted, tried}, and step sizes.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			cnt_rd_q  <= cnt_mem[rd_addr];
			step_rd_q <= step_mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
		if (state_q == S_EX && out_free && ex_ok) begin
			if ((req_q.req_type == REQ_ACCEPT || req_q.req_type == REQ_REJECT)
				&& cur_tr != CNT_MAX)
				cnt_mem[ex_addr] <= {(req_q.req_type == REQ_ACCEPT && cur_ac != CNT_MAX)
					? cur_ac + CW'(1) : cur_ac, cur_tr + CW'(1)};
			if (req_q.req_type == REQ_WRITE)
				step_mem[ex_addr] <= wr_step;
		end
		if (state_q == S_WB && out_free)
			step_mem[scan_idx] <= tn_step_q;
	end

	// Request sequencer, tune datapath and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			skip_q      <= SKIP_RESET;
			conc_q      <= CONC_RESET;
			cvalid_q    <= '0;
			svalid_q    <= '0;
			act_q       <= '0;
			scan_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// Configuration writes.
			if (psel && penable && pwrite) begin
				unique case (paddr[2])
					REG_SKIP: skip_q <= pwdata[MASK_BITS-1:0];
					REG_CONC: conc_q <= pwdata[MASK_BITS-1:0];
					default:  ;
				endcase
			end
			if (rsp_set)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q   <= req;
						state_q <= S_EX;
					end
				end
				S_EX: begin
					case (req_q.req_type) inside
						REQ_ACCEPT, REQ_REJECT: begin
							if (out_free) begin
								state_q <= S_IDLE;
								if (!ex_ok) begin
									rsp_q <= '{status: 1'b1, out_index: req_q.move_index,
										out_value: '0, last: 1'b1};
								end else begin
									if (cur_tr != CNT_MAX) begin
										cvalid_q[ex_addr] <= 1'b1;
										act_q[ex_addr]    <= 1'b1;
									end
									rsp_q <= '{status: 1'b0, out_index: req_q.move_index,
										out_value: 32'(XW'(cur_step)), last: 1'b1};
								end
							end
						end
						REQ_TUNE: begin
							scan_q  <= '0;
							state_q <= S_SCAN;
						end
						REQ_CLEAR: begin
							if (out_free) begin
								cvalid_q <= '0;
								act_q    <= '0;
								rsp_q    <= '{status: 1'b0, out_index: '0, out_value: '0,
									last: 1'b1};
								state_q  <= S_IDLE;
							end
						end
						REQ_WRITE: begin
							if (out_free) begin
								if (ex_ok) begin
									svalid_q[ex_addr] <= 1'b1;
									rsp_q <= '{status: 1'b0, out_index: req_q.move_index,
										out_value: 32'(XW'(wr_step)), last: 1'b1};
								end else begin
									rsp_q <= '{status: 1'b0, out_index: '0, out_value: '0,
										last: 1'b1};
								end
								state_q <= S_IDLE;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_SCAN: begin
					if (scan_q == SCW'(NUM_MOVES))
						state_q <= S_IDLE;
					else if (act_q[scan_idx])
						state_q <= S_LOAD;
					else
						scan_q <= scan_q + SCW'(1);
				end
				S_LOAD: begin
					// Start the rate division, or pass the step through when skipped.
					tn_step_q  <= cur_step;
					dv_num_q   <= DVW'({ac_clamp, 16'b0});
					dv_den_q   <= DSW'(cur_tr);
					dv_rem_q   <= '0;
					dv_cnt_q   <= '0;
					dv_phase_q <= PH_RATE;
					state_q    <= mask_skip_x[5'(scan_q)] ? S_WB : S_DIV;
				end
				S_DIV: begin
					if (dv_cnt_q != DCW'(DVW)) begin
						dv_rem_q <= qbit ? (rem_sh - {1'b0, dv_den_q}) : rem_sh;
						dv_num_q <= {dv_num_q[DVW-2:0], qbit};
						dv_cnt_q <= dv_cnt_q + DCW'(1);
					end else begin
						dv_rem_q <= '0;
						dv_cnt_q <= '0;
						case (dv_phase_q)
							PH_RATE: begin
								// Distance of the rate above the target, or the rate itself when at or below it.
								gt_q    <= (rate > RATE_TARGET);
								up_q    <= (rate > RATE_TARGET) ^ mask_conc_x[5'(scan_q)];
								fx_q    <= (rate > RATE_TARGET) ? 16'(rate - RATE_TARGET)
									: rate;
								state_q <= S_FAC;
							end
							default: begin
								tn_step_q <= div_step;
								state_q   <= S_WB;
							end
						endcase
					end
				end
				S_FAC: begin
					// Apply the factor by multiplying or by dividing.
					if (up_q) begin
						prod_q  <= '0;
						mc_q    <= PW'(tn_step_q);
						mp_q    <= fac;
						state_q <= S_MUL;
					end else begin
						dv_num_q   <= DVW'({tn_step_q, 16'b0});
						dv_den_q   <= DSW'(fac);
						dv_phase_q <= PH_STEP;
						state_q    <= S_DIV;
					end
				end
				S_MUL: begin
					// Shift-add multiply of the step by the factor.
					if (dv_cnt_q != DCW'(FBITS)) begin
						if (mp_q[0])
							prod_q <= prod_q + mc_q;
						mc_q     <= {mc_q[PW-2:0], 1'b0};
						mp_q     <= {1'b0, mp_q[FBITS-1:1]};
						dv_cnt_q <= dv_cnt_q + DCW'(1);
					end else begin
						dv_cnt_q  <= '0;
						tn_step_q <= mul_step;
						state_q   <= S_WB;
					end
				end
				S_WB: begin
					// Store the step, clear the counters and report this move.
					if (out_free) begin
						svalid_q[scan_idx] <= 1'b1;
						cvalid_q[scan_idx] <= 1'b0;
						act_q[scan_idx]    <= 1'b0;
						rsp_q <= '{status: 1'b0, out_index: 4'(6'(scan_q)),
							out_value: 32'(XW'(tn_step_q)), last: tune_last};
						scan_q  <= scan_q + SCW'(1);
						state_q <= S_SCAN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== bench/tb_mcmc_acceptance_step_tuner_core.sv =====
// Testbench for the step tuner core: directed and random requests checked against a predictor.
`default_nettype none
module tb_mcmc_acceptance_step_tuner_core;
	import mast_pkg::*;

	localparam int NMOV = 9;
	localparam logic [63:0] CNT_MAX = 64'hFFFF_FFFF;
	localparam logic [63:0] STP_MAX = 64'hFFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// Predictor state.
	logic [63:0] acc_cnt [NMOV];
	logic [63:0] try_cnt [NMOV];
	logic [63:0] step_sz [NMOV];
	logic [8:0] skip_m;
	logic [8:0] conc_m;
	rsp_t pending_rsp [$];
	int errors = 0;
	int send_idle = 0;
	int recv_idle = 0;

	mcmc_acceptance_step_tuner_core u_dut (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [63:0] clamp_step(logic [63:0] v);
		if (v > STP_MAX) v = STP_MAX;
		if (v == 0) v = 1;
		return v;
	endfunction

	// New step size of one move from its counters.
	function automatic logic [63:0] tuned_step(int i);
		logic [63:0] tr, ac, r, f, s;
		logic up;
		tr = try_cnt[i];
		ac = acc_cnt[i];
		s = step_sz[i];
		if (ac > tr) ac = tr;
		r = (ac << 16) / tr;
		if (r > 65535) r = 65535;
		if (r > RATE_TARGET) begin
			f = 65536 + ((r - RATE_TARGET) << 16) / RATE_REST;
			up = 1'b1;
		end else begin
			f = 131072 - (r << 16) / RATE_TARGET;
			up = 1'b0;
		end
		if (conc_m[i]) up = !up;
		if (up) return clamp_step((s >> 16) * f + (((s & 64'hFFFF) * f) >> 16));
		return clamp_step((s << 16) / f);
	endfunction

	function automatic rsp_t mk(logic st, logic [3:0] idx, logic [31:0] val, logic lst);
		rsp_t x;
		x.status = st;
		x.out_index = idx;
		x.out_value = val;
		x.last = lst;
		return x;
	endfunction

	// Works out the results of one accepted request word.
	task automatic predict_request(req_t w);
		int lastk;
		logic ok;
		ok = w.move_index < NMOV;
		case (w.req_type)
			REQ_ACCEPT, REQ_REJECT: begin
				if (!ok) begin
					pending_rsp.push_back(mk(1'b1, w.move_index, 32'd0, 1'b1));
				end else begin
					if (try_cnt[w.move_index] < CNT_MAX) begin
						try_cnt[w.move_index]++;
						if (w.req_type == REQ_ACCEPT && acc_cnt[w.move_index] < CNT_MAX)
							acc_cnt[w.move_index]++;
					end
					pending_rsp.push_back(mk(1'b0, w.move_index,
						step_sz[w.move_index][31:0], 1'b1));
				end
			end
			REQ_TUNE: begin
				lastk = -1;
				for (int i = 0; i < NMOV; i++) if (try_cnt[i] > 0) lastk = i;
				for (int i = 0; i < NMOV; i++) begin
					if (try_cnt[i] == 0) continue;
					if (!skip_m[i]) step_sz[i] = tuned_step(i);
					acc_cnt[i] = 0;
					try_cnt[i] = 0;
					pending_rsp.push_back(mk(1'b0, i[3:0], step_sz[i][31:0], i == lastk));
				end
			end
			REQ_CLEAR: begin
				for (int i = 0; i < NMOV; i++) begin
					acc_cnt[i] = 0;
					try_cnt[i] = 0;
				end
				pending_rsp.push_back(mk(1'b0, 4'd0, 32'd0, 1'b1));
			end
			REQ_WRITE: begin
				if (!ok) begin
					pending_rsp.push_back(mk(1'b0, 4'd0, 32'd0, 1'b1));
				end else begin
					step_sz[w.move_index] = {32'd0, w.step_value};
					pending_rsp.push_back(mk(1'b0, w.move_index, w.step_value, 1'b1));
				end
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	// Sends one request word; the prediction is made when it is accepted.
	task automatic send_word(logic [2:0] rt, logic [3:0] mi, logic [31:0] sv);
		req_t w;
		w.req_type = rt;
		w.move_index = mi;
		w.step_value = sv;
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (req_stall);
		predict_request(w);
	endtask

	// Result checker and receiver stall generator.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					report_mismatch("unexpected word", {31'd0, rsp.last}, 32'd0);
				end else begin
					want = pending_rsp.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", 32'(rsp.status), 32'(want.status));
					if (rsp.out_index !== want.out_index)
						report_mismatch("out_index", 32'(rsp.out_index), 32'(want.out_index));
					if (rsp.out_value !== want.out_value)
						report_mismatch("out_value", rsp.out_value, want.out_value);
					if (rsp.last !== want.last)
						report_mismatch("last", 32'(rsp.last), 32'(want.last));
				end
			end
			rsp_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	task automatic drain();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	// Register write; the block is idle whenever this is called.
	task automatic write_reg(logic addr_sel, logic [8:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {addr_sel, 2'b00};
		pwdata <= {16'($urandom_range(65535)), 7'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr_sel == REG_SKIP) skip_m = val;
		else conc_m = val;
		@(posedge clk);
	endtask

	task automatic set_masks(logic [8:0] sk, logic [8:0] cm);
		drain();
		write_reg(REG_SKIP, sk);
		write_reg(REG_CONC, cm);
	endtask

	task automatic test_directed();
		send_word(REQ_ACCEPT, 4'd0, 32'hFFFF_FFFF);
		send_word(REQ_REJECT, 4'd8, 32'd0);
		send_word(REQ_ACCEPT, 4'd9, 32'd0);
		send_word(REQ_REJECT, 4'd15, 32'd0);
		send_word(REQ_WRITE, 4'd1, 32'hFFFF_FFFF);
		send_word(REQ_WRITE, 4'd2, 32'd0);
		send_word(REQ_WRITE, 4'd12, 32'h1234_5678);
		send_word(REQ_ACCEPT, 4'd1, 32'd0);
		send_word(REQ_ACCEPT, 4'd2, 32'd0);
		send_word(REQ_REJECT, 4'd2, 32'd0);
		send_word(REQ_ACCEPT, 4'd5, 32'd0);
		send_word(REQ_ACCEPT, 4'd3, 32'd0);
		send_word(REQ_TUNE, 4'd0, 32'd0);
		send_word(REQ_TUNE, 4'd0, 32'd0);
		send_word(REQ_REJECT, 4'd4, 32'd0);
		send_word(REQ_CLEAR, 4'd9, 32'd0);
		send_word(REQ_TUNE, 4'd0, 32'd0);
		send_word(3'd5, 4'd3, 32'd0);
		send_word(3'd7, 4'd0, 32'd0);
		send_word(REQ_WRITE, 4'd7, 32'h0000_0001);
		send_word(REQ_REJECT, 4'd7, 32'd0);
		send_word(REQ_TUNE, 4'd0, 32'd0);
	endtask

	// Random sessions: bursts of accept/reject then a tune, with some noise.
	task automatic test_random(int n_items);
		int k, p;
		k = 0;
		while (k < n_items) begin
			p = $urandom_range(99);
			if (p < 70) send_word(3'($urandom_range(1)), 4'($urandom_range(8)), $urandom());
			else if (p < 78) send_word(REQ_TUNE, 4'($urandom_range(15)), $urandom());
			else if (p < 86) send_word(REQ_WRITE, 4'($urandom_range(15)),
				$urandom_range(1) ? $urandom() : $urandom_range(131072, 1));
			else if (p < 90) send_word(REQ_CLEAR, 4'($urandom_range(15)), $urandom());
			else if (p < 95) send_word(3'($urandom_range(1)), 4'($urandom_range(15, 9)),
				$urandom());
			else send_word(3'($urandom_range(7, 5)), 4'($urandom_range(15)), $urandom());
			k++;
		end
		send_word(REQ_TUNE, 4'd0, 32'd0);
	endtask

	task automatic test_hold_off();
		send_word(REQ_ACCEPT, 4'd6, 32'd0);
		drain();
		send_word(REQ_TUNE, 4'd0, 32'd0);
	endtask

	initial begin
		for (int i = 0; i < NMOV; i++) begin
			acc_cnt[i] = 0;
			try_cnt[i] = 0;
			step_sz[i] = 65536;
		end
		skip_m = SKIP_RESET;
		conc_m = CONC_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_hold_off();
		set_masks(9'd0, 9'd0);
		test_random(90);
		send_idle = 79;
		set_masks(9'h1FF, 9'h1FF);
		test_random(40);
		send_idle = 0;
		recv_idle = 79;
		set_masks(9'($urandom_range(511)), 9'($urandom_range(511)));
		test_random(90);
		send_idle = 33;
		recv_idle = 33;
		set_masks(9'($urandom_range(511)), 9'($urandom_range(511)));
		test_random(90);
		send_idle = 0;
		recv_idle = 0;
		set_masks(9'd96, 9'd254);
		test_random(40);
		drain();
		if (errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

	initial begin
		#40000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire
